### sv/lrp_pkg.sv
`timescale 1ns / 1ps

package lrp_pkg;

	// Input item modes
	localparam logic MODE_START = 1'b0;
	localparam logic MODE_STEP  = 1'b1;

	// One rectangle command as it leaves the block
	typedef struct packed {
		logic        valid_res;
		logic [7:0]  col_start;
		logic [7:0]  row_start;
		logic [7:0]  col_end;
		logic [7:0]  row_end;
		logic [15:0] color565;
		logic        last;
	} out_beat_t;

	// Pack 8:8:8 (blue high, red low) into RGB565 with blue on top
	function automatic logic [15:0] to_565(input logic [23:0] c24);
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
		b = c24[23:16];
		g = c24[15:8];
		r = c24[7:0];
		return {b[7:3], g[7:2], r[7:3]};
	endfunction

endpackage

### sv/lrp_walk.sv
`timescale 1ns / 1ps

// One Bresenham step: move the point and update the error term
module lrp_walk #(
	parameter int CW = 8
) (
	input  logic [CW-1:0]        cur_col,
	input  logic [CW-1:0]        cur_row,
	input  logic [CW-1:0]        span_x,
	input  logic [CW-1:0]        span_y,
	input  logic                 dir_x_neg,
	input  logic                 dir_y_neg,
	input  logic signed [CW+1:0] err_term,
	output logic [CW-1:0]        col_next,
	output logic [CW-1:0]        row_next,
	output logic signed [CW+1:0] err_next
);

	localparam int EW = CW + 2;

	logic signed [EW:0] e2;
	logic signed [EW:0] sx_w;
	logic signed [EW:0] sy_w;
	logic               step_x;
	logic               step_y;

	// Compare the doubled error against both spans
	assign e2     = $signed({err_term, 1'b0});
	assign sx_w   = $signed({3'b000, span_x});
	assign sy_w   = $signed({3'b000, span_y});
	assign step_x = e2 > -sy_w;
	assign step_y = e2 < sx_w;

	// Advance each axis that steps, wrapping at the coordinate width
	assign col_next = !step_x ? cur_col :
		(dir_x_neg ? cur_col - CW'(1) : cur_col + CW'(1));
	assign row_next = !step_y ? cur_row :
		(dir_y_neg ? cur_row - CW'(1) : cur_row + CW'(1));
	assign err_next = err_term
		- (step_x ? $signed({2'b00, span_y}) : EW'(0))
		+ (step_y ? $signed({2'b00, span_x}) : EW'(0));

endmodule

### sv/lrp_obuf.sv
`timescale 1ns / 1ps

// Two-entry output buffer: main register plus skid register
module lrp_obuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	input  lrp_pkg::out_beat_t  push_beat,
	output logic                push_stall,
	output logic                pop_valid,
	input  logic                pop_stall,
	output lrp_pkg::out_beat_t  pop_beat
);

	logic               main_valid_q;
	logic               skid_valid_q;
	lrp_pkg::out_beat_t main_q;
	lrp_pkg::out_beat_t skid_q;
	logic               main_free;

	// Main register may load when empty or being drained this cycle
	assign main_free  = !main_valid_q || !pop_stall;
	assign push_stall = skid_valid_q;
	assign pop_valid  = main_valid_q;
	assign pop_beat   = main_q;

	// Track occupancy of both entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push_valid;
			end
		end else if (push_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Move payload: skid drains first, else a new beat lands
	always_ff @(posedge clk) begin
		if (main_free) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else begin
				main_q <= push_beat;
			end
		end else if (push_valid && !skid_valid_q) begin
			skid_q <= push_beat;
		end
	end

endmodule

### sv/line_rasterizer_rect_pen.sv
`timescale 1ns / 1ps

// Pull-style Bresenham line generator with a rectangular pen. A start beat
// (mode 0) latches both end points, the pen size and the colour and returns
// the first point; each step beat (mode 1) returns the next point of the
// line, the end point being flagged last. A step with no line in progress
// returns a beat with valid_res low and all other fields zero. One beat is
// taken every clock cycle while in_stall is low: the whole step (one
// compare-and-add on the error term) sits between the input port and the
// output buffer, so a result is registered there as its item is taken. A
// two-entry output buffer keeps the input open while a result waits;
// in_stall rises only when both entries are full.
module line_rasterizer_rect_pen #(
	parameter int COORD_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [7:0]  x_start,
	input  logic [7:0]  y_start,
	input  logic [7:0]  x_end,
	input  logic [7:0]  y_end,
	input  logic [7:0]  pen_size,
	input  logic [23:0] color24,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        valid_res,
	output logic [7:0]  col_start,
	output logic [7:0]  row_start,
	output logic [7:0]  col_end,
	output logic [7:0]  row_end,
	output logic [15:0] color565,
	output logic        last
);

	localparam int CW = COORD_BITS;
	localparam int EW = COORD_BITS + 2;

	// Line state
	logic                 line_active_q;
	logic [CW-1:0]        cur_col_q;
	logic [CW-1:0]        cur_row_q;
	logic [CW-1:0]        end_col_q;
	logic [CW-1:0]        end_row_q;
	logic [CW-1:0]        span_x_q;
	logic [CW-1:0]        span_y_q;
	logic                 dir_x_neg_q;
	logic                 dir_y_neg_q;
	logic signed [EW-1:0] err_term_q;
	logic [7:0]           pen_width_q;
	logic [15:0]          pen_color_q;

	// Next-state values
	logic                 line_active_n;
	logic [CW-1:0]        cur_col_n;
	logic [CW-1:0]        cur_row_n;
	logic [CW-1:0]        end_col_n;
	logic [CW-1:0]        end_row_n;
	logic [CW-1:0]        span_x_n;
	logic [CW-1:0]        span_y_n;
	logic                 dir_x_neg_n;
	logic                 dir_y_neg_n;
	logic signed [EW-1:0] err_term_n;
	logic [7:0]           pen_width_n;
	logic [15:0]          pen_color_n;

	logic                 accept;
	logic                 push_stall;
	logic                 at_end;
	lrp_pkg::out_beat_t   beat;
	lrp_pkg::out_beat_t   pop_beat;

	// Start-beat decode
	logic [CW-1:0]        x1;
	logic [CW-1:0]        y1;
	logic [CW-1:0]        x2;
	logic [CW-1:0]        y2;
	logic [CW-1:0]        sx;
	logic [CW-1:0]        sy;

	// Step datapath
	logic [CW-1:0]        col_step;
	logic [CW-1:0]        row_step;
	logic signed [EW-1:0] err_step;

	assign in_stall = push_stall;
	assign accept   = in_valid && !push_stall;

	// Clip the coordinates to the coordinate width
	assign x1 = CW'(x_start);
	assign y1 = CW'(y_start);
	assign x2 = CW'(x_end);
	assign y2 = CW'(y_end);
	assign sx = (x2 > x1) ? (x2 - x1) : (x1 - x2);
	assign sy = (y2 > y1) ? (y2 - y1) : (y1 - y2);

	// Advance one Bresenham step from the held state
	lrp_walk #(
		.CW (CW)
	) u_walk (
		.cur_col   (cur_col_q),
		.cur_row   (cur_row_q),
		.span_x    (span_x_q),
		.span_y    (span_y_q),
		.dir_x_neg (dir_x_neg_q),
		.dir_y_neg (dir_y_neg_q),
		.err_term  (err_term_q),
		.col_next  (col_step),
		.row_next  (row_step),
		.err_next  (err_step)
	);

	// Select next state and build the result beat
	always_comb begin
		line_active_n = line_active_q;
		cur_col_n     = cur_col_q;
		cur_row_n     = cur_row_q;
		end_col_n     = end_col_q;
		end_row_n     = end_row_q;
		span_x_n      = span_x_q;
		span_y_n      = span_y_q;
		dir_x_neg_n   = dir_x_neg_q;
		dir_y_neg_n   = dir_y_neg_q;
		err_term_n    = err_term_q;
		pen_width_n   = pen_width_q;
		pen_color_n   = pen_color_q;
		beat          = '0;
		at_end        = 1'b0;
		if (mode == lrp_pkg::MODE_START) begin
			cur_col_n   = x1;
			cur_row_n   = y1;
			end_col_n   = x2;
			end_row_n   = y2;
			span_x_n    = sx;
			span_y_n    = sy;
			dir_x_neg_n = !(x1 < x2);
			dir_y_neg_n = !(y1 < y2);
			err_term_n  = $signed({2'b00, sx}) - $signed({2'b00, sy});
			pen_width_n = pen_size;
			pen_color_n = lrp_pkg::to_565(color24);
		end else if (line_active_q) begin
			cur_col_n  = col_step;
			cur_row_n  = row_step;
			err_term_n = err_step;
		end
		if (mode == lrp_pkg::MODE_START || line_active_q) begin
			at_end          = (cur_col_n == end_col_n) && (cur_row_n == end_row_n);
			line_active_n   = !at_end;
			beat.valid_res  = 1'b1;
			beat.col_start  = 8'(cur_col_n);
			beat.row_start  = 8'(cur_row_n);
			beat.col_end    = 8'(cur_col_n) + pen_width_n;
			beat.row_end    = 8'(cur_row_n) + pen_width_n;
			beat.color565   = pen_color_n;
			beat.last       = at_end;
		end
	end

	// Hold the line state, update on each taken beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_active_q <= 1'b0;
			cur_col_q     <= '0;
			cur_row_q     <= '0;
			end_col_q     <= '0;
			end_row_q     <= '0;
			span_x_q      <= '0;
			span_y_q      <= '0;
			dir_x_neg_q   <= 1'b0;
			dir_y_neg_q   <= 1'b0;
			err_term_q    <= '0;
			pen_width_q   <= '0;
			pen_color_q   <= '0;
		end else if (accept) begin
			line_active_q <= line_active_n;
			cur_col_q     <= cur_col_n;
			cur_row_q     <= cur_row_n;
			end_col_q     <= end_col_n;
			end_row_q     <= end_row_n;
			span_x_q      <= span_x_n;
			span_y_q      <= span_y_n;
			dir_x_neg_q   <= dir_x_neg_n;
			dir_y_neg_q   <= dir_y_neg_n;
			err_term_q    <= err_term_n;
			pen_width_q   <= pen_width_n;
			pen_color_q   <= pen_color_n;
		end
	end

	// Buffer results toward the output port
	lrp_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (accept),
		.push_beat  (beat),
		.push_stall (push_stall),
		.pop_valid  (out_valid),
		.pop_stall  (out_stall),
		.pop_beat   (pop_beat)
	);

	assign valid_res = pop_beat.valid_res;
	assign col_start = pop_beat.col_start;
	assign row_start = pop_beat.row_start;
	assign col_end   = pop_beat.col_end;
	assign row_end   = pop_beat.row_end;
	assign color565  = pop_beat.color565;
	assign last      = pop_beat.last;

endmodule
